@@ rtl/ccm_pkg.sv @@
`timescale 1ns / 1ps

package ccm_pkg;

  // flag store geometry
  localparam int unsigned SLOTS = 4096;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned SLOT_CNT_W = 13;
  localparam int unsigned CNT_W     = 64;
  localparam int unsigned UNIQ_W    = 13;
  localparam int unsigned OUTC_W    = 14;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    FUNC_INSTR  = 2'd0,
    FUNC_BRANCH = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_SLOTS = 1'd1;

  localparam logic [SLOT_CNT_W-1:0] REGION_SLOTS_RST = 13'd4096;

  // flag bit positions
  localparam int unsigned FLAG_EXEC      = 0;
  localparam int unsigned FLAG_TAKEN     = 1;
  localparam int unsigned FLAG_NOT_TAKEN = 2;

  typedef struct packed {
    func_t              func;
    logic [ADDR_W-1:0]  address;
    logic               taken;
  } in_item_t;

  typedef struct packed {
    logic              in_range;
    logic [2:0]        slot_flags;
    logic [CNT_W-1:0]  instructions;
    logic [CNT_W-1:0]  outside_hits;
    logic [CNT_W-1:0]  branch_events;
    logic [CNT_W-1:0]  taken_events;
    logic [CNT_W-1:0]  not_taken_events;
    logic [UNIQ_W-1:0] unique_executed;
    logic [UNIQ_W-1:0] branch_sites_seen;
    logic [OUTC_W-1:0] branch_outcomes_seen;
    logic [UNIQ_W-1:0] fully_covered_sites;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             exec;
    logic             sweep_we;
    logic [IDX_W-1:0] sweep_addr;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_item;
  } dp_status_t;

endpackage

@@ rtl/ccm_ctrl.sv @@
`timescale 1ns / 1ps

module ccm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ccm_pkg::dp_status_t status,
  output ccm_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                      state_r;
  logic [ccm_pkg::IDX_W-1:0]   sweep_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_cnt_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (start) state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          if (status.clear_item) begin
            state_r     <= ST_SWEEP;
            sweep_cnt_r <= '0;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_SWEEP: begin
          if (sweep_cnt_r == ccm_pkg::IDX_W'(ccm_pkg::SLOTS - 1)) begin
            state_r <= ST_IDLE;
          end else begin
            sweep_cnt_r <= sweep_cnt_r + 1'b1;
          end
        end
        default: state_r <= ST_SWEEP;
      endcase
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign cmd.load       = (state_r == ST_IDLE) && start;
  assign cmd.exec       = (state_r == ST_EXEC);
  assign cmd.sweep_we   = (state_r == ST_SWEEP);
  assign cmd.sweep_addr = sweep_cnt_r;

endmodule

@@ rtl/ccm_datapath.sv @@
`timescale 1ns / 1ps

module ccm_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ccm_pkg::in_item_t                   in_data,
  input  logic                                cfg_we,
  input  logic [ccm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ccm_pkg::ADDR_W-1:0]          cfg_data,
  input  ccm_pkg::ctrl_cmd_t                  cmd,
  output ccm_pkg::dp_status_t                 status,
  output logic                                out_valid,
  output ccm_pkg::out_item_t                  out_data
);

  // configuration
  logic [ccm_pkg::ADDR_W-1:0]     region_base_r;
  logic [ccm_pkg::SLOT_CNT_W-1:0] region_slots_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r  <= '0;
      region_slots_r <= ccm_pkg::REGION_SLOTS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ccm_pkg::CFG_REGION_BASE:  region_base_r  <= cfg_data;
        ccm_pkg::CFG_REGION_SLOTS: region_slots_r <= cfg_data[ccm_pkg::SLOT_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // window test on the incoming address
  logic [ccm_pkg::ADDR_W-1:0] base_even;
  logic [ccm_pkg::ADDR_W-1:0] diff;
  logic [ccm_pkg::ADDR_W-1:0] limit;
  logic [ccm_pkg::ADDR_W-1:0] slot;
  logic                       in_win;

  assign base_even = {region_base_r[ccm_pkg::ADDR_W-1:1], 1'b0};
  assign diff      = in_data.address - base_even;
  assign slot      = {1'b0, diff[ccm_pkg::ADDR_W-1:1]};
  assign limit     = (ccm_pkg::ADDR_W'(region_slots_r) > ccm_pkg::ADDR_W'(ccm_pkg::SLOTS)) ?
                     ccm_pkg::ADDR_W'(ccm_pkg::SLOTS) : ccm_pkg::ADDR_W'(region_slots_r);
  assign in_win    = !in_data.address[0] && (in_data.address >= base_even) && (slot < limit);

  // latched item
  ccm_pkg::func_t             func_r;
  logic                       taken_r;
  logic                       inside_r;
  logic [ccm_pkg::IDX_W-1:0]  idx_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_data.func;
      taken_r  <= in_data.taken;
      inside_r <= in_win;
      idx_r    <= diff[ccm_pkg::IDX_W:1];
    end
  end

  // flag store
  logic [2:0]                flag_mem [ccm_pkg::SLOTS];
  logic [2:0]                rdata_r;
  logic                      mem_we;
  logic [ccm_pkg::IDX_W-1:0] mem_waddr;
  logic [2:0]                mem_wdata;
  logic [2:0]                nf;

  always_ff @(posedge clk) begin
    if (mem_we) flag_mem[mem_waddr] <= mem_wdata;
    if (cmd.load) rdata_r <= flag_mem[diff[ccm_pkg::IDX_W:1]];
  end

  // counters
  logic [ccm_pkg::CNT_W-1:0]  instr_cnt_r, outside_cnt_r, branch_cnt_r;
  logic [ccm_pkg::CNT_W-1:0]  taken_cnt_r, not_taken_cnt_r;
  logic [ccm_pkg::UNIQ_W-1:0] exec_uniq_r, site_uniq_r, full_site_r;
  logic [ccm_pkg::OUTC_W-1:0] outc_uniq_r;

  logic inc_instr, inc_outside, inc_branch, inc_taken, inc_not_taken;
  logic inc_exec_u, inc_site_u, inc_outc_u, inc_full;
  logic [2:0] hit, other;

  always_comb begin
    nf            = rdata_r;
    inc_instr     = 1'b0;
    inc_outside   = 1'b0;
    inc_branch    = 1'b0;
    inc_taken     = 1'b0;
    inc_not_taken = 1'b0;
    inc_exec_u    = 1'b0;
    inc_site_u    = 1'b0;
    inc_outc_u    = 1'b0;
    inc_full      = 1'b0;
    hit           = '0;
    other         = '0;
    hit[taken_r ? ccm_pkg::FLAG_TAKEN : ccm_pkg::FLAG_NOT_TAKEN]   = 1'b1;
    other[taken_r ? ccm_pkg::FLAG_NOT_TAKEN : ccm_pkg::FLAG_TAKEN] = 1'b1;
    case (func_r)
      ccm_pkg::FUNC_INSTR: begin
        inc_instr = 1'b1;
        if (!inside_r) begin
          inc_outside = 1'b1;
        end else if (!rdata_r[ccm_pkg::FLAG_EXEC]) begin
          nf[ccm_pkg::FLAG_EXEC] = 1'b1;
          inc_exec_u             = 1'b1;
        end
      end
      ccm_pkg::FUNC_BRANCH: begin
        if (inside_r) begin
          inc_branch    = 1'b1;
          inc_taken     = taken_r;
          inc_not_taken = !taken_r;
          inc_site_u    = !rdata_r[ccm_pkg::FLAG_TAKEN] && !rdata_r[ccm_pkg::FLAG_NOT_TAKEN];
          if ((rdata_r & hit) == 3'b000) begin
            nf         = rdata_r | hit;
            inc_outc_u = 1'b1;
            inc_full   = ((rdata_r & other) != 3'b000);
          end
        end
      end
      ccm_pkg::FUNC_QUERY: ;
      ccm_pkg::FUNC_CLEAR: nf = '0;
      default: ;
    endcase
  end

  logic do_clear;
  assign do_clear = cmd.exec && (func_r == ccm_pkg::FUNC_CLEAR);

  always_ff @(posedge clk) begin
    if (!rst_n || do_clear) begin
      instr_cnt_r     <= '0;
      outside_cnt_r   <= '0;
      branch_cnt_r    <= '0;
      taken_cnt_r     <= '0;
      not_taken_cnt_r <= '0;
      exec_uniq_r     <= '0;
      site_uniq_r     <= '0;
      outc_uniq_r     <= '0;
      full_site_r     <= '0;
    end else if (cmd.exec) begin
      instr_cnt_r     <= instr_cnt_r     + ccm_pkg::CNT_W'(inc_instr);
      outside_cnt_r   <= outside_cnt_r   + ccm_pkg::CNT_W'(inc_outside);
      branch_cnt_r    <= branch_cnt_r    + ccm_pkg::CNT_W'(inc_branch);
      taken_cnt_r     <= taken_cnt_r     + ccm_pkg::CNT_W'(inc_taken);
      not_taken_cnt_r <= not_taken_cnt_r + ccm_pkg::CNT_W'(inc_not_taken);
      exec_uniq_r     <= exec_uniq_r     + ccm_pkg::UNIQ_W'(inc_exec_u);
      site_uniq_r     <= site_uniq_r     + ccm_pkg::UNIQ_W'(inc_site_u);
      outc_uniq_r     <= outc_uniq_r     + ccm_pkg::OUTC_W'(inc_outc_u);
      full_site_r     <= full_site_r     + ccm_pkg::UNIQ_W'(inc_full);
    end
  end

  // write port: sweep or read-modify-write of the latched entry
  assign mem_we    = cmd.sweep_we || (cmd.exec && inside_r &&
                     (func_r == ccm_pkg::FUNC_INSTR || func_r == ccm_pkg::FUNC_BRANCH));
  assign mem_waddr = cmd.sweep_we ? cmd.sweep_addr : idx_r;
  assign mem_wdata = cmd.sweep_we ? 3'b000 : nf;

  // result
  logic       out_valid_r;
  logic       in_range_r;
  logic [2:0] flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.exec;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      in_range_r <= inside_r;
      flags_r    <= inside_r ? nf : 3'b000;
    end
  end

  assign status.clear_item = (func_r == ccm_pkg::FUNC_CLEAR);

  assign out_valid                     = out_valid_r;
  assign out_data.in_range             = in_range_r;
  assign out_data.slot_flags           = flags_r;
  assign out_data.instructions         = instr_cnt_r;
  assign out_data.outside_hits         = outside_cnt_r;
  assign out_data.branch_events        = branch_cnt_r;
  assign out_data.taken_events         = taken_cnt_r;
  assign out_data.not_taken_events     = not_taken_cnt_r;
  assign out_data.unique_executed      = exec_uniq_r;
  assign out_data.branch_sites_seen    = site_uniq_r;
  assign out_data.branch_outcomes_seen = outc_uniq_r;
  assign out_data.fully_covered_sites  = full_site_r;

endmodule

@@ rtl/code_coverage_monitor_top.sv @@
`timescale 1ns / 1ps

// coverage monitor over a program address window, one 3-bit flag entry per
// two-byte slot. an item is taken when start is high and busy low; each item
// gives exactly one result beat, out_valid high for one cycle, and the
// receiver cannot stall it. for an instruction, branch or query item the
// flag entry is read when the item is accepted and the execute state then
// writes it back (in-window instruction and branch items only) and registers
// the result; busy is high in the execute state, so a new item is taken only
// after the last one has executed. a clear item returns its result, then
// holds busy for a sweep of all SLOTS entries, zeroing the flag memory one
// entry a cycle through its single write port; the same sweep runs after
// reset, and start is first taken once it ends. configuration writes are
// always accepted (cfg_ready is tied high), including during the sweep
module code_coverage_monitor_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // command channel
  input  logic                             start,
  output logic                             busy,
  input  ccm_pkg::in_item_t                in_data,
  // result channel, no back-pressure
  output logic                             out_valid,
  output ccm_pkg::out_item_t               out_data,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ccm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccm_pkg::ADDR_W-1:0]       cfg_data
);

  ccm_pkg::ctrl_cmd_t  cmd;
  ccm_pkg::dp_status_t status;

  // registers can be written at any time
  assign cfg_ready = 1'b1;

  // sequencing: idle, item execute, flag memory sweep
  ccm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // window test, flag memory, counters and result registers
  ccm_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ verif/coverage_check_pkg.sv @@
`timescale 1ns / 1ps

package coverage_check_pkg;

  import ccm_pkg::*;

  // tracks the coverage state of the monitor and the reports it should return
  class coverage_tracker;

    logic [ADDR_W-1:0]     region_base;
    logic [SLOT_CNT_W-1:0] region_slots;

    bit [2:0]        flag_mem [SLOTS];
    bit [CNT_W-1:0]  instr_cnt;
    bit [CNT_W-1:0]  outside_cnt;
    bit [CNT_W-1:0]  branch_cnt;
    bit [CNT_W-1:0]  taken_cnt;
    bit [CNT_W-1:0]  not_taken_cnt;
    bit [UNIQ_W-1:0] exec_uniq;
    bit [UNIQ_W-1:0] site_uniq;
    bit [OUTC_W-1:0] outcome_uniq;
    bit [UNIQ_W-1:0] full_sites;

    out_item_t   expected_reports [$];
    int unsigned failures;

    function new();
      region_base  = '0;
      region_slots = REGION_SLOTS_RST;
      failures     = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (flag_mem[i]) flag_mem[i] = '0;
      instr_cnt     = '0;
      outside_cnt   = '0;
      branch_cnt    = '0;
      taken_cnt     = '0;
      not_taken_cnt = '0;
      exec_uniq     = '0;
      site_uniq     = '0;
      outcome_uniq  = '0;
      full_sites    = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
      case (idx)
        CFG_REGION_BASE:  region_base = data;
        CFG_REGION_SLOTS: region_slots = data[SLOT_CNT_W-1:0];
        default: ;
      endcase
    endfunction

    // bit 0 of the base is ignored
    function logic [ADDR_W-1:0] window_base();
      return {region_base[ADDR_W-1:1], 1'b0};
    endfunction

    // slot count clipped to the store depth
    function int unsigned window_slots();
      return (32'(region_slots) > SLOTS) ? SLOTS : 32'(region_slots);
    endfunction

    function bit locate(logic [ADDR_W-1:0] addr, output int unsigned slot);
      logic [ADDR_W-1:0] offs;
      slot = 0;
      if (addr[0] || addr < window_base()) return 1'b0;
      offs = addr - window_base();
      if ((offs >> 1) >= window_slots()) return 1'b0;
      slot = offs >> 1;
      return 1'b1;
    endfunction

    function void note_item(in_item_t item);
      int unsigned idx;
      bit          in_win;
      bit [2:0]    f;
      bit [2:0]    hit;
      bit [2:0]    other;
      out_item_t   want;
      in_win = locate(item.address, idx);
      case (item.func)
        FUNC_INSTR: begin
          if (!in_win) begin
            outside_cnt++;
          end else if (!flag_mem[idx][FLAG_EXEC]) begin
            flag_mem[idx][FLAG_EXEC] = 1'b1;
            exec_uniq++;
          end
          instr_cnt++;
        end
        FUNC_BRANCH: begin
          // out-of-window or odd branch sites leave everything alone
          if (in_win) begin
            f     = flag_mem[idx];
            hit   = item.taken ? (3'b1 << FLAG_TAKEN) : (3'b1 << FLAG_NOT_TAKEN);
            other = item.taken ? (3'b1 << FLAG_NOT_TAKEN) : (3'b1 << FLAG_TAKEN);
            if (!f[FLAG_TAKEN] && !f[FLAG_NOT_TAKEN]) site_uniq++;
            if ((f & hit) == 3'b0) begin
              f = f | hit;
              outcome_uniq++;
              if ((f & other) != 3'b0) full_sites++;
            end
            flag_mem[idx] = f;
            branch_cnt++;
            if (item.taken) taken_cnt++;
            else not_taken_cnt++;
          end
        end
        FUNC_QUERY: ;
        FUNC_CLEAR: wipe();
        default: ;
      endcase
      want.in_range             = in_win;
      want.slot_flags           = in_win ? flag_mem[idx] : 3'b0;
      want.instructions         = instr_cnt;
      want.outside_hits         = outside_cnt;
      want.branch_events        = branch_cnt;
      want.taken_events         = taken_cnt;
      want.not_taken_events     = not_taken_cnt;
      want.unique_executed      = exec_uniq;
      want.branch_sites_seen    = site_uniq;
      want.branch_outcomes_seen = outcome_uniq;
      want.fully_covered_sites  = full_sites;
      expected_reports.push_back(want);
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction

    function void check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (expected_reports.size() == 0) begin
        $error("result beat with no item outstanding");
        failures++;
        return;
      end
      want = expected_reports.pop_front();
      check_field("in_range", 64'(want.in_range), 64'(got.in_range));
      check_field("slot_flags", 64'(want.slot_flags), 64'(got.slot_flags));
      check_field("instructions", want.instructions, got.instructions);
      check_field("outside_hits", want.outside_hits, got.outside_hits);
      check_field("branch_events", want.branch_events, got.branch_events);
      check_field("taken_events", want.taken_events, got.taken_events);
      check_field("not_taken_events", want.not_taken_events, got.not_taken_events);
      check_field("unique_executed", 64'(want.unique_executed), 64'(got.unique_executed));
      check_field("branch_sites_seen", 64'(want.branch_sites_seen),
                  64'(got.branch_sites_seen));
      check_field("branch_outcomes_seen", 64'(want.branch_outcomes_seen),
                  64'(got.branch_outcomes_seen));
      check_field("fully_covered_sites", 64'(want.fully_covered_sites),
                  64'(got.fully_covered_sites));
    endfunction

  endclass

endpackage

@@ verif/code_coverage_monitor_top_tb.sv @@
`timescale 1ns / 1ps

module code_coverage_monitor_top_tb;

  import ccm_pkg::*;
  import coverage_check_pkg::*;

  // longest legal quiet stretch is a clear sweep plus a sender gap,
  // so this leaves a wide margin
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned HOT_N      = 16;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_data;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [ADDR_W-1:0]     cfg_data;

  coverage_tracker tracker;
  int unsigned     idle_cycles;
  int unsigned     hot_slots [HOT_N];
  int unsigned     gap_mode;

  code_coverage_monitor_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // all handshakes are observed here, at the rising edge, in one place:
  // a command beat updates the tracked state before any result beat of the
  // same edge is checked, so a same-cycle result cannot race its own item
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) tracker.note_item(in_data);
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (out_valid) tracker.check_report(out_data);
      // watchdog: any beat on any channel counts as progress
      if ((start && !busy) || (cfg_valid && cfg_ready) || out_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // drop start and wait until every result is back and the block is not sweeping
  task automatic wait_idle();
    start = 1'b0;
    while (tracker.pending() != 0 || busy !== 1'b0) @(negedge clk);
  endtask

  // one configuration beat, only issued with the block idle
  task automatic set_window_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [ADDR_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one command beat; entered and left at a falling edge, start stays high
  // across back-to-back items
  task automatic drive_item(input func_t f, input logic [ADDR_W-1:0] addr,
                            input logic tk, input int unsigned gap);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.func    = f;
    in_data.address = addr;
    in_data.taken   = tk;
    start           = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  // a handful of slots that get hit over and over, so sites collect both
  // branch outcomes and the unique counters see repeats
  task automatic pick_hot_slots();
    int unsigned lim;
    lim = tracker.window_slots();
    foreach (hot_slots[j]) hot_slots[j] = (lim == 0) ? 0 : $urandom_range(0, lim - 1);
    if (lim != 0) begin
      hot_slots[0] = 0;
      hot_slots[1] = lim - 1;
    end
  endtask

  // mostly even in-window addresses, the rest odd, just below, just above
  // or anywhere in the address space
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned       r;
    int unsigned       lim;
    int unsigned       slot;
    logic [ADDR_W-1:0] b;
    r   = $urandom_range(0, 99);
    lim = tracker.window_slots();
    b   = tracker.window_base();
    if (lim != 0 && r < 75) begin
      slot = ($urandom_range(0, 2) != 0) ? hot_slots[$urandom_range(0, HOT_N - 1)]
                                         : $urandom_range(0, lim - 1);
      return b + 2 * slot;
    end
    if (r < 82) return b + 2 * $urandom_range(0, SLOTS - 1) + 1;
    if (r < 88) return b - 2 * $urandom_range(1, 64);
    if (r < 94) return b + 2 * (lim + $urandom_range(0, 64));
    return $urandom();
  endfunction

  task automatic run_random(input int unsigned count);
    int unsigned i;
    int unsigned r;
    int unsigned gap;
    func_t       f;
    pick_hot_slots();
    for (i = 0; i < count; i++) begin
      // idling style changes every 40 items: none, short gaps, full range
      if (i % 40 == 0) gap_mode = $urandom_range(0, 2);
      r = $urandom_range(0, 999);
      // clears are rare since each one costs a full sweep
      f = (r < 420) ? FUNC_INSTR : (r < 820) ? FUNC_BRANCH :
          (r < 985) ? FUNC_QUERY : FUNC_CLEAR;
      gap = (gap_mode == 0) ? 0 :
            (gap_mode == 1) ? $urandom_range(0, 3) : $urandom_range(0, 18);
      drive_item(f, pick_address(), 1'($urandom_range(0, 1)), gap);
    end
    wait_idle();
  endtask

  initial begin
    tracker     = new();
    idle_cycles = 0;
    gap_mode    = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset window, base 0 and 4096 slots
    drive_item(FUNC_QUERY, 32'h0000_0000, 1'b0, 0);   // never-touched entry
    drive_item(FUNC_INSTR, 32'h0000_0000, 1'b0, 0);
    drive_item(FUNC_INSTR, 32'h0000_0000, 1'b1, 3);   // repeat, no new unique
    drive_item(FUNC_BRANCH, 32'h0000_0000, 1'b1, 0);
    drive_item(FUNC_BRANCH, 32'h0000_0000, 1'b1, 0);  // same outcome again
    drive_item(FUNC_BRANCH, 32'h0000_0000, 1'b0, 18); // site now fully covered
    drive_item(FUNC_QUERY, 32'h0000_0000, 1'b0, 0);
    drive_item(FUNC_INSTR, 32'h0000_0001, 1'b0, 0);   // odd address is outside
    drive_item(FUNC_BRANCH, 32'h0000_0003, 1'b1, 1);  // odd branch ignored
    drive_item(FUNC_INSTR, 32'h0000_1FFE, 1'b0, 0);   // last slot
    drive_item(FUNC_INSTR, 32'h0000_2000, 1'b0, 0);   // one past the window
    drive_item(FUNC_BRANCH, 32'h0000_2000, 1'b0, 0);  // out-of-window branch ignored
    drive_item(FUNC_BRANCH, 32'h0000_1FFE, 1'b0, 2);
    drive_item(FUNC_QUERY, 32'hFFFF_FFFF, 1'b1, 0);   // query outside
    drive_item(FUNC_CLEAR, 32'h0000_1FFE, 1'b0, 0);   // clear keeps the window test
    drive_item(FUNC_QUERY, 32'h0000_1FFE, 1'b0, 0);

    // top of the address space with an empty window
    set_window_reg(CFG_REGION_BASE, 32'hFFFF_FFFF);
    set_window_reg(CFG_REGION_SLOTS, 32'd0);
    drive_item(FUNC_INSTR, 32'hFFFF_FFFE, 1'b0, 0);
    drive_item(FUNC_BRANCH, 32'hFFFF_FFFE, 1'b1, 0);

    // oversized slot count gets clipped to the store depth
    set_window_reg(CFG_REGION_SLOTS, 32'd8191);
    drive_item(FUNC_BRANCH, 32'hFFFF_FFFE, 1'b0, 0);
    drive_item(FUNC_INSTR, 32'h0000_0000, 1'b0, 0);   // below base

    // odd base, old flags stay and are seen through the new window
    set_window_reg(CFG_REGION_BASE, 32'h0000_1001);
    drive_item(FUNC_INSTR, 32'h0000_1000, 1'b0, 0);
    drive_item(FUNC_INSTR, 32'h0000_0FFE, 1'b0, 0);
    drive_item(FUNC_BRANCH, 32'h0000_2FFE, 1'b1, 0);
    drive_item(FUNC_INSTR, 32'h0000_3000, 1'b0, 0);
    drive_item(FUNC_QUERY, 32'h0000_1000, 1'b0, 0);

    // random phases, each under its own window
    set_window_reg(CFG_REGION_BASE, 32'h0000_0000);
    set_window_reg(CFG_REGION_SLOTS, 32'd4096);
    run_random(300);

    set_window_reg(CFG_REGION_BASE, $urandom());
    set_window_reg(CFG_REGION_SLOTS, 32'd1);
    run_random(150);

    set_window_reg(CFG_REGION_BASE, 32'hFFFF_FFFF);
    set_window_reg(CFG_REGION_SLOTS, $urandom_range(1, 4096));
    run_random(150);

    set_window_reg(CFG_REGION_BASE, $urandom());
    set_window_reg(CFG_REGION_SLOTS, 32'd16);
    run_random(250);

    // only the slot count moves; upper data bits are junk and must be dropped
    set_window_reg(CFG_REGION_SLOTS, 32'hFFFF_E000 | $urandom_range(1, 4096));
    run_random(250);

    set_window_reg(CFG_REGION_BASE, $urandom());
    set_window_reg(CFG_REGION_SLOTS, 32'd8191);
    run_random(200);

    set_window_reg(CFG_REGION_BASE, $urandom());
    set_window_reg(CFG_REGION_SLOTS, 32'd0);
    run_random(60);

    set_window_reg(CFG_REGION_BASE, $urandom_range(0, 65535));
    set_window_reg(CFG_REGION_SLOTS, 32'd64);
    run_random(340);

    // drain, then a few more edges to catch any stray result beat
    wait_idle();
    repeat (12) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
